### sv/ceac_pkg.sv
// Shared types and constants for the CRC encode and check unit.
package ceac_pkg;

    // Degree values up to 64 fit here
    localparam int DEG_W = 7;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_DEGREE = 2'd0;
    localparam logic [1:0] REG_TAPS   = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_CHECK  = 1'b1;

    localparam logic [5:0]  DEGREE_RESET = 6'd8;
    localparam logic [31:0] TAPS_RESET   = 32'd7;

    typedef enum logic [1:0] {
        KIND_ECHO     = 2'd0,
        KIND_ECHO_REM = 2'd1,
        KIND_CHECK    = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              data_bit;
        logic              check_ok;
        logic [DEG_W-1:0]  degree;
    } job_t;

endpackage

### sv/crc_encode_and_check_unit.sv
// Top level of the CRC encode and check unit.
// Bit-serial CRC with a configurable generator (degree 1..MAX_DEGREE, leading one implied).
// One input bit is accepted per clock unless full is high. In encode mode each bit yields
// one result, and the final bit of a message yields one more result per remainder bit, so
// a message of n bits produces n + degree results; the back-end remainder shifter emits one
// result per cycle while the output register is empty or popped. Input bits keep flowing
// while that runs until the four-entry job queue between front and back fills, then full
// rises. In check mode only the final bit of a message produces a result (the pass/fail
// flag). A result reaches the result ports through the queue and the output register.
// Configuration registers sit at byte addresses 0 (degree), 4 (taps) and 8 (mode) and must
// be written only while no message is in flight.
module crc_encode_and_check_unit #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ceac_pkg::ADDR_W-1:0]  paddr,
    input  logic [ceac_pkg::DATA_W-1:0]  pwdata,
    output logic [ceac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic                         data_bit,
    input  logic                         last_bit,
    output logic                         empty,
    input  logic                         pop,
    output logic                         out_bit,
    output logic                         is_remainder,
    output logic                         check_ok,
    output logic                         out_last
);

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    ceac_pkg::job_t        wr_job;
    ceac_pkg::job_t        rd_job;
    logic [MAX_DEGREE-1:0] wr_rem;
    logic [MAX_DEGREE-1:0] rd_rem;

    ceac_front #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .data_bit  (data_bit),
        .last_bit  (last_bit),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (wr_job),
        .q_rem     (wr_rem)
    );

    ceac_queue #(
        .REM_W (MAX_DEGREE)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (wr_job),
        .wr_rem  (wr_rem),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_job  (rd_job),
        .rd_rem  (rd_rem)
    );

    ceac_back #(
        .MAX_DEGREE (MAX_DEGREE)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (rd_job),
        .q_rem        (rd_rem),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .out_bit      (out_bit),
        .is_remainder (is_remainder),
        .check_ok     (check_ok),
        .out_last     (out_last)
    );

endmodule

### sv/ceac_front.sv
// Front end: configuration registers, remainder update and job classification.
module ceac_front #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ceac_pkg::ADDR_W-1:0]  paddr,
    input  logic [ceac_pkg::DATA_W-1:0]  pwdata,
    output logic [ceac_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         push,
    output logic                         full,
    input  logic                         data_bit,
    input  logic                         last_bit,
    input  logic                         q_full,
    output logic                         q_push,
    output ceac_pkg::job_t               q_job,
    output logic [MAX_DEGREE-1:0]        q_rem
);

    localparam int DW = ceac_pkg::DEG_W;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DEGREE);

    logic [5:0]            crc_degree_reg;
    logic [31:0]           poly_taps_reg;
    logic                  mode_reg;
    logic [MAX_DEGREE-1:0] remainder_reg;
    logic [MAX_DEGREE-1:0] remainder_next;

    logic                  cfg_write;
    logic [1:0]            reg_index;
    logic [DW-1:0]         deg_ext;
    logic [DW-1:0]         eff_deg;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] top_sel;
    logic [MAX_DEGREE+31:0] taps_wide;
    logic [MAX_DEGREE-1:0] taps;
    logic [MAX_DEGREE-1:0] cur;
    logic [MAX_DEGREE-1:0] step;
    logic                  top;
    logic                  feedback;
    logic                  accept;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_index)
            ceac_pkg::REG_DEGREE: prdata = {26'd0, crc_degree_reg};
            ceac_pkg::REG_TAPS:   prdata = poly_taps_reg;
            ceac_pkg::REG_MODE:   prdata = {31'd0, mode_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_degree_reg <= ceac_pkg::DEGREE_RESET;
            poly_taps_reg  <= ceac_pkg::TAPS_RESET;
            mode_reg       <= ceac_pkg::MODE_ENCODE;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                ceac_pkg::REG_DEGREE: crc_degree_reg <= pwdata[5:0];
                ceac_pkg::REG_TAPS:   poly_taps_reg  <= pwdata;
                ceac_pkg::REG_MODE:   mode_reg       <= pwdata[0];
                default:              ;
            endcase
        end
    end

    // Clamp degree into 1..MAX_DEGREE
    always_comb
    begin
        deg_ext = {1'b0, crc_degree_reg};
        priority if (deg_ext == '0)
            eff_deg = DW'(1);
        else if (deg_ext > MAX_D)
            eff_deg = MAX_D;
        else
            eff_deg = deg_ext;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_DEGREE; i++)
        begin
            mask[i]    = (DW'(i) < eff_deg);
            top_sel[i] = (DW'(i + 1) == eff_deg);
        end
    end

    assign taps_wide = {MAX_DEGREE'(0), poly_taps_reg};
    assign taps      = taps_wide[MAX_DEGREE-1:0] & mask;
    assign cur       = remainder_reg & mask;
    assign top       = |(cur & top_sel);
    assign feedback  = (mode_reg == ceac_pkg::MODE_ENCODE) ? (top ^ data_bit) : top;

    always_comb
    begin
        if (mode_reg == ceac_pkg::MODE_ENCODE)
            step = (cur << 1) & mask;
        else
            step = ((cur << 1) | MAX_DEGREE'(data_bit)) & mask;
        remainder_next = feedback ? (step ^ taps) : step;
    end

    assign full   = q_full;
    assign accept = push && !q_full;
    assign q_push = accept && ((mode_reg == ceac_pkg::MODE_ENCODE) || last_bit);
    assign q_rem  = remainder_next;

    always_comb
    begin
        q_job.data_bit = data_bit;
        q_job.check_ok = (remainder_next == '0);
        q_job.degree   = eff_deg;
        if (mode_reg == ceac_pkg::MODE_CHECK)
            q_job.kind = ceac_pkg::KIND_CHECK;
        else if (last_bit)
            q_job.kind = ceac_pkg::KIND_ECHO_REM;
        else
            q_job.kind = ceac_pkg::KIND_ECHO;
    end

    // Clear the remainder after the final bit of each message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remainder_reg <= '0;
        else if (accept)
            remainder_reg <= last_bit ? '0 : remainder_next;
    end

endmodule

### sv/ceac_queue.sv
// Short job queue between the front end and the result sequencer.
module ceac_queue #(
    parameter int REM_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  ceac_pkg::job_t   wr_job,
    input  logic [REM_W-1:0] wr_rem,
    output logic             q_full,
    input  logic             rd_en,
    output logic             q_empty,
    output ceac_pkg::job_t   rd_job,
    output logic [REM_W-1:0] rd_rem
);

    localparam int PW = ceac_pkg::Q_PTR_W;
    localparam int CW = ceac_pkg::Q_CNT_W;

    ceac_pkg::job_t   job_mem [ceac_pkg::Q_DEPTH];
    logic [REM_W-1:0] rem_mem [ceac_pkg::Q_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_wr;
    logic             do_rd;

    assign q_full  = (count_reg == CW'(ceac_pkg::Q_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_job  = job_mem[rd_ptr_reg];
    assign rd_rem  = rem_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            job_mem[wr_ptr_reg] <= wr_job;
            rem_mem[wr_ptr_reg] <= wr_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

### sv/ceac_back.sv
// Back end: turns queued jobs into result transfers, shifting out remainders.
module ceac_back #(
    parameter int MAX_DEGREE = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  ceac_pkg::job_t        q_job,
    input  logic [MAX_DEGREE-1:0] q_rem,
    output logic                  q_pop,
    input  logic                  pop,
    output logic                  empty,
    output logic                  out_bit,
    output logic                  is_remainder,
    output logic                  check_ok,
    output logic                  out_last
);

    localparam int DW = ceac_pkg::DEG_W;

    logic                  out_valid_reg;
    logic                  out_bit_reg;
    logic                  is_rem_reg;
    logic                  check_ok_reg;
    logic                  out_last_reg;
    logic [DW-1:0]         ser_cnt_reg;
    logic [DW-1:0]         ser_cnt_next;
    logic [MAX_DEGREE-1:0] ser_rem_reg;
    logic [MAX_DEGREE-1:0] ser_sel;
    logic                  ser_bit;
    logic                  slot_free;
    logic                  serializing;

    assign empty        = !out_valid_reg;
    assign out_bit      = out_bit_reg;
    assign is_remainder = is_rem_reg;
    assign check_ok     = check_ok_reg;
    assign out_last     = out_last_reg;

    assign slot_free   = !out_valid_reg || pop;
    assign serializing = (ser_cnt_reg != '0);
    assign q_pop       = slot_free && !serializing && !q_empty;

    always_comb
    begin
        for (int i = 0; i < MAX_DEGREE; i++)
            ser_sel[i] = (DW'(i + 1) == ser_cnt_reg);
    end

    assign ser_bit      = |(ser_rem_reg & ser_sel);
    assign ser_cnt_next = ser_cnt_reg - DW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ser_cnt_reg   <= '0;
        end
        else if (slot_free)
        begin
            if (serializing)
            begin
                out_valid_reg <= 1'b1;
                ser_cnt_reg   <= ser_cnt_next;
            end
            else if (!q_empty)
            begin
                out_valid_reg <= 1'b1;
                if (q_job.kind == ceac_pkg::KIND_ECHO_REM)
                    ser_cnt_reg <= q_job.degree;
            end
            else
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (serializing)
            begin
                out_bit_reg  <= ser_bit;
                is_rem_reg   <= 1'b1;
                check_ok_reg <= 1'b0;
                out_last_reg <= (ser_cnt_reg == DW'(1));
            end
            else if (!q_empty)
            begin
                ser_rem_reg <= q_rem;
                unique case (q_job.kind)
                    ceac_pkg::KIND_CHECK:
                    begin
                        out_bit_reg  <= 1'b0;
                        is_rem_reg   <= 1'b0;
                        check_ok_reg <= q_job.check_ok;
                        out_last_reg <= 1'b1;
                    end
                    default:
                    begin
                        out_bit_reg  <= q_job.data_bit;
                        is_rem_reg   <= 1'b0;
                        check_ok_reg <= 1'b0;
                        out_last_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

endmodule
